// ----- rtl/sli_pkg.sv -----
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LIST   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ins;
    logic del;
    logic list_start;
    logic list_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic found;
    logic list_last;
  } stat_t;

endpackage

// ----- rtl/sli_dp.sv -----
module sli_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sli_pkg::cmd_t                     cmd,
  input  logic signed [sli_pkg::DATA_W-1:0] value,
  output sli_pkg::stat_t                    stat,
  output logic signed [sli_pkg::DATA_W-1:0] out_entry
);
  import sli_pkg::*;

  logic signed [DATA_W-1:0] ent_r   [CAPACITY];
  logic signed [DATA_W-1:0] ent_nxt [CAPACITY];
  logic        [CNT_W-1:0]  count_r, count_nxt;
  logic        [IDX_W-1:0]  idx_r, idx_nxt;
  logic signed [DATA_W-1:0] entry_r, entry_nxt;
  logic [CAPACITY-1:0]      ge, eq, at_or_after;

  // per-cell compares against the incoming word
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (ent_r[i] >= value);
      eq[i] = (CNT_W'(i) < count_r) && (ent_r[i] == value);
    end
  end

  // marks cells at or after the first match
  always_comb begin
    at_or_after[0] = eq[0];
    for (int i = 1; i < CAPACITY; i++) begin
      at_or_after[i] = at_or_after[i-1] | eq[i];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_nxt[i] = ent_r[i];
      if (cmd.ins) begin
        if (i > 0 && ge[(i > 0) ? i-1 : 0]) begin
          ent_nxt[i] = ent_r[(i > 0) ? i-1 : 0];
        end else if (ge[i] || CNT_W'(i) == count_r) begin
          ent_nxt[i] = value;
        end
      end else if (cmd.del) begin
        if (at_or_after[i] && i < CAPACITY - 1) begin
          ent_nxt[i] = ent_r[(i < CAPACITY - 1) ? i+1 : i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.list_start) begin
      idx_nxt = '0;
    end else if (cmd.list_step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.out_load) begin
      entry_nxt = cmd.list_step ? ent_r[idx_r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    entry_r <= entry_nxt;
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r >= CNT_W'(CAPACITY));
  assign stat.found     = |eq;
  assign stat.list_last = ({1'b0, idx_r} == CNT_W'(count_r - CNT_W'(1)));
  assign out_entry      = entry_r;

endmodule

// ----- rtl/sli_ctrl.sv -----
module sli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_mode,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic           out_last,
  input  sli_pkg::stat_t stat,
  output sli_pkg::cmd_t  cmd
);
  import sli_pkg::*;

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t status_r, status_nxt;
  logic    last_r, last_nxt;
  logic    out_free, acc;
  mode_t   mode;

  assign mode     = mode_t'(in_mode);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == S_LIST) || !out_free;
  assign acc      = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && mode == MODE_LIST && !stat.empty) begin
          state_nxt = S_LIST;
        end
      end
      S_LIST: begin
        if (out_free && stat.list_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands and result word
  always_comb begin
    cmd        = '0;
    status_nxt = STS_OK;
    last_nxt   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (mode)
            MODE_INSERT: begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                status_nxt = STS_FULL;
              end else begin
                cmd.ins = 1'b1;
              end
            end
            MODE_DELETE: begin
              cmd.out_load = 1'b1;
              if (stat.empty) begin
                status_nxt = STS_EMPTY;
              end else if (stat.found) begin
                cmd.del = 1'b1;
              end else begin
                status_nxt = STS_NOT_FOUND;
              end
            end
            MODE_LIST: begin
              if (stat.empty) begin
                cmd.out_load = 1'b1;
                status_nxt   = STS_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          cmd.list_step = 1'b1;
          cmd.out_load  = 1'b1;
          last_nxt      = stat.list_last;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_last   = last_r;

endmodule

// ----- rtl/sorted_list_insert_delete_top.sv -----
// insert and delete: result valid the cycle after accept
// list: read index then entry register; one entry per cycle while out_stall is low
// input is held off while a list is streaming or a result waits on out_stall
// throughput one word per cycle for insert, delete and an empty list while out_stall is low
// synchronous active-low reset empties the list; entry cells are not cleared
module sorted_list_insert_delete_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic signed [sli_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [sli_pkg::DATA_W-1:0] out_entry,
  output logic                              out_last
);
  import sli_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_last   (out_last),
    .stat       (stat),
    .cmd        (cmd)
  );

  sli_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .value     (in_value),
    .stat      (stat),
    .out_entry (out_entry)
  );

endmodule

// ----- rtl/sli_checker.sv -----
module sli_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        in_mode,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        out_status,
  input logic signed [sli_pkg::DATA_W-1:0] out_entry,
  input logic                              out_last
);
  import sli_pkg::*;

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_entry)
      && $stable(out_last))
    else $error("stalled result word changed");

  // error results carry no entry and end the item
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_entry == '0 && out_last)
    else $error("error result with entry or without last");

  // no new word while the result register is held
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  // insert and delete answer with one final result next cycle
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_INSERT || in_mode == MODE_DELETE)
      |=> out_valid && out_last)
    else $error("insert or delete did not answer");

endmodule

bind sorted_list_insert_delete_top sli_checker u_sli_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  typedef struct {
    logic                     pause;
    mode_t                    mode;
    logic signed [DATA_W-1:0] value;
  } op_word_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] entry;
    logic                     last;
  } due_word_t;

  localparam int HOLD_CYCLES = 80;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic [1:0]               in_mode   = MODE_NONE;
  logic signed [DATA_W-1:0] in_value  = '0;
  logic                     out_stall = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_entry;
  logic                     out_last;

  op_word_t                 pending_ops[$];
  due_word_t                due_words[$];
  logic signed [DATA_W-1:0] stored_vals[$];
  logic signed [DATA_W-1:0] recent_vals[$];

  logic in_fire    = 1'b0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   fail_count = 0;
  int   hold_req   = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;

  sorted_list_insert_delete_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_entry  (out_entry),
    .out_last   (out_last)
  );

  always #5 clk = ~clk;

  task automatic queue_word(input status_t st, input logic signed [DATA_W-1:0] ent,
                            input logic lst);
    due_word_t w;
    w.status = st;
    w.entry  = ent;
    w.last   = lst;
    due_words.push_back(w);
  endtask

  // sorted list behavior, updates stored_vals and queues the words it causes
  task automatic compute_list_results(input mode_t m, input logic signed [DATA_W-1:0] v);
    int pos;
    int n;
    n = stored_vals.size();
    case (m)
      MODE_INSERT: begin
        if (n >= CAPACITY) begin
          queue_word(STS_FULL, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < n && stored_vals[pos] < v) pos++;
          stored_vals.insert(pos, v);
          queue_word(STS_OK, '0, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (n == 0) begin
          queue_word(STS_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < n && stored_vals[pos] !== v) pos++;
          if (pos == n) begin
            queue_word(STS_NOT_FOUND, '0, 1'b1);
          end else begin
            stored_vals.delete(pos);
            queue_word(STS_OK, '0, 1'b1);
          end
        end
      end
      MODE_LIST: begin
        if (n == 0) begin
          queue_word(STS_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) queue_word(STS_OK, stored_vals[i], i == n - 1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_words
    due_word_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word status %0d entry %0d last %0b",
                     $realtime, out_status, out_entry, out_last);
        end else begin
          want = due_words.pop_front();
          if (out_status !== want.status || out_entry !== want.entry ||
              out_last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp status %0d entry %0d last %0b, got %0d %0d %0b",
                       $realtime, want.status, want.entry, want.last,
                       out_status, out_entry, out_last);
          end
        end
      end
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) compute_list_results(mode_t'(in_mode), in_value);
    end
  end

  always @(negedge clk) begin : drive_ops
    op_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_ops.size() != 0 && pending_ops[0].pause) begin
        // hold the sender until every word is back
        in_valid <= 1'b0;
        if (due_words.size() == 0) void'(pending_ops.pop_front());
      end else if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_mode  <= nxt.mode;
        in_value <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_op(input mode_t m, input logic signed [DATA_W-1:0] v);
    op_word_t w;
    w.pause = 1'b0;
    w.mode  = m;
    w.value = v;
    pending_ops.push_back(w);
  endtask

  task automatic push_pause();
    op_word_t w;
    w.pause = 1'b1;
    w.mode  = MODE_NONE;
    w.value = '0;
    pending_ops.push_back(w);
  endtask

  // extremes, a narrow band for duplicates, or anything
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'sh8000_0000;
    if (r < 10) return 32'sh7fff_ffff;
    if (r < 40) return int'($urandom_range(6)) - 3;
    return $urandom;
  endfunction

  task automatic push_random(input int n, input int ins_pct);
    int r;
    logic signed [DATA_W-1:0] v;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < ins_pct) begin
        v = pick_value();
        push_op(MODE_INSERT, v);
        recent_vals.push_back(v);
        if (recent_vals.size() > 24) void'(recent_vals.pop_front());
      end else if (r < 88) begin
        if (recent_vals.size() != 0 && $urandom_range(3) != 0)
          v = recent_vals[$urandom_range(recent_vals.size() - 1)];
        else
          v = pick_value();
        push_op(MODE_DELETE, v);
      end else if (r < 97) begin
        push_op(MODE_LIST, $urandom);
      end else begin
        push_op(MODE_NONE, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    int idle_set[4]  = '{0, 64, 0, 13};
    int stall_set[4] = '{0, 0, 64, 13};
    int ins_set[4]   = '{65, 40, 55, 35};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_op(MODE_LIST, 32'sh1234_5678);
    push_op(MODE_DELETE, 32'sd7);
    push_op(MODE_INSERT, 32'sd0);
    push_op(MODE_INSERT, 32'sh7fff_ffff);
    push_op(MODE_INSERT, 32'sh8000_0000);
    push_op(MODE_INSERT, -32'sd1);
    push_op(MODE_INSERT, 32'sd0);
    // equal to the head goes in front of it
    push_op(MODE_INSERT, 32'sh8000_0000);
    push_op(MODE_LIST, '1);
    push_op(MODE_DELETE, 32'sd5);
    push_op(MODE_DELETE, 32'sh8000_0000);
    push_op(MODE_DELETE, 32'sd0);
    push_op(MODE_NONE, 32'sh5555_aaaa);
    push_op(MODE_LIST, '0);
    for (int i = 0; i < 12; i++) push_op(MODE_INSERT, $urandom);
    push_op(MODE_INSERT, 32'sd3);
    push_op(MODE_LIST, '0);
    push_pause();

    for (int ph = 0; ph < 4; ph++) begin
      while (pending_ops.size() != 0) @(negedge clk);
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 0) hold_req++;
      push_random(33, ins_set[ph]);
      push_pause();
    end

    while (pending_ops.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (due_words.size() != 0) fail_count++;
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sorted_list_insert_delete_top.f -----
rtl/sli_pkg.sv
rtl/sli_dp.sv
rtl/sli_ctrl.sv
rtl/sorted_list_insert_delete_top.sv
rtl/sli_checker.sv
tb/testbench.sv
